>>> hw/rtl/vtld_pkg.sv
package vtld_pkg;

	// widths fixed by the frame format
	localparam int unsigned ACC_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned CONT_BIT = 7;
	localparam int unsigned SHIFT_W = 6;

	// header byte limit before the header is thrown away
	localparam int unsigned MAX_HEADER_BYTES_DEF = 10;

	// event codes on the result channel
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	// one result transfer
	typedef struct packed {
		kind_t              kind;
		logic [ACC_W-1:0]   msg_type;
		logic [ACC_W-1:0]   msg_len;
		logic [BYTE_W-1:0]  payload;
		logic               last;
	} res_t;

endpackage

>>> hw/rtl/vtld_core.sv
module vtld_core #(
	parameter int unsigned MAX_HEADER_BYTES = vtld_pkg::MAX_HEADER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [vtld_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          has_res,
	output vtld_pkg::res_t                res
);

	localparam int unsigned CNT_W = $clog2(MAX_HEADER_BYTES + 1);

	// frame state
	logic                          in_body_q, in_body_d;
	logic                          type_done_q, type_done_d;
	logic [vtld_pkg::SHIFT_W-1:0]  shift_q, shift_d;
	logic [CNT_W-1:0]              cnt_q, cnt_d;
	logic [vtld_pkg::ACC_W-1:0]    type_q, type_d;
	logic [vtld_pkg::ACC_W-1:0]    len_q, len_d;
	logic [vtld_pkg::ACC_W-1:0]    remain_q, remain_d;

	// group placement at the current bit position
	logic [vtld_pkg::GROUP_BITS-1:0] group;
	logic                            cont;
	logic                            add_en;
	logic                            first;
	logic [vtld_pkg::ACC_W-1:0]      shifted;
	logic [vtld_pkg::ACC_W-1:0]      type_base, len_base, type_new, len_new;
	logic [CNT_W-1:0]                cnt_inc;
	logic                            body_last;
	logic                            check_ovf;

	assign group = rx_byte[vtld_pkg::GROUP_BITS-1:0];
	assign cont = rx_byte[vtld_pkg::CONT_BIT];
	assign add_en = !shift_q[vtld_pkg::SHIFT_W-1];
	assign shifted = vtld_pkg::ACC_W'(group) << shift_q[vtld_pkg::SHIFT_W-2:0];
	assign first = (cnt_q == '0);
	assign type_base = first ? '0 : type_q;
	assign len_base = first ? '0 : len_q;
	assign type_new = (!type_done_q && add_en) ? (type_base | shifted) : type_base;
	assign len_new = (type_done_q && add_en) ? (len_base | shifted) : len_base;
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign body_last = (remain_q <= vtld_pkg::ACC_W'(1));

	// next state and result for the byte in hand
	always_comb begin
		in_body_d = in_body_q;
		type_done_d = type_done_q;
		shift_d = shift_q;
		cnt_d = cnt_q;
		type_d = type_q;
		len_d = len_q;
		remain_d = remain_q;
		has_res = 1'b0;
		check_ovf = 1'b0;
		res.kind = vtld_pkg::KIND_PAYLOAD;
		res.msg_type = '0;
		res.msg_len = '0;
		res.payload = '0;
		res.last = 1'b0;
		if (in_body_q) begin
			has_res = 1'b1;
			res.kind = vtld_pkg::KIND_PAYLOAD;
			res.msg_type = type_q;
			res.msg_len = len_q;
			res.payload = rx_byte;
			res.last = body_last;
			if (body_last) begin
				remain_d = '0;
				in_body_d = 1'b0;
			end else begin
				remain_d = remain_q - vtld_pkg::ACC_W'(1);
			end
		end else begin
			type_d = type_new;
			len_d = len_new;
			cnt_d = cnt_inc;
			if (!cont) begin
				if (!type_done_q) begin
					type_done_d = 1'b1;
					shift_d = '0;
					check_ovf = 1'b1;
				end else begin
					// header complete
					type_done_d = 1'b0;
					shift_d = '0;
					cnt_d = '0;
					if (len_new == '0) begin
						has_res = 1'b1;
						res.kind = vtld_pkg::KIND_EMPTY;
						res.msg_type = type_new;
						res.last = 1'b1;
					end else begin
						in_body_d = 1'b1;
						remain_d = len_new;
					end
				end
			end else begin
				if (add_en) begin
					shift_d = shift_q + vtld_pkg::SHIFT_W'(vtld_pkg::GROUP_BITS);
				end
				check_ovf = 1'b1;
			end
			// header too long: drop it and flag
			if (check_ovf && (cnt_inc >= CNT_W'(MAX_HEADER_BYTES))) begin
				type_done_d = 1'b0;
				shift_d = '0;
				cnt_d = '0;
				has_res = 1'b1;
				res.kind = vtld_pkg::KIND_OVERFLOW;
			end
		end
	end

	// state update on each transfer through the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			type_done_q <= 1'b0;
			shift_q <= '0;
			cnt_q <= '0;
			type_q <= '0;
			len_q <= '0;
			remain_q <= '0;
		end else if (fire) begin
			in_body_q <= in_body_d;
			type_done_q <= type_done_d;
			shift_q <= shift_d;
			cnt_q <= cnt_d;
			type_q <= type_d;
			len_q <= len_d;
			remain_q <= remain_d;
		end
	end

`ifndef NO_ASSERTIONS
	// header count is cleared before it reaches the limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_HEADER_BYTES))
		else $error("header count past limit");

	// a body byte always gives a payload result
	a_body_payload: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_body_q |-> has_res && (res.kind == vtld_pkg::KIND_PAYLOAD))
		else $error("body byte without payload result");

	// a body in progress always has bytes left
	a_body_remain: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (remain_q != '0))
		else $error("body with nothing remaining");

	// an empty message closes with zero length and last set
	a_empty_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		has_res && (res.kind == vtld_pkg::KIND_EMPTY) |-> res.last && (res.msg_len == '0))
		else $error("malformed empty message event");
`endif

endmodule

>>> hw/rtl/varint_type_length_deframer.sv
// varint type/length deframer
// rx channel: one link byte per transfer (rx_valid, rx_stall, rx_byte).
// res channel: zero or one result per byte (res_valid, res_stall and the
// result fields kind, message_type, message_length, payload_byte,
// last_of_message). header bytes give no result except when an empty
// message completes or the header overflows and is discarded.
// a byte taken into the input register is decoded there, and its result
// is loaded into the result register as the byte leaves the input register.
// throughput: one byte per cycle while rx_stall is low; the decode is a
// single registered step between the input register and the result register.
// a stalled receiver holds the result register; the input register can
// still take one more byte, and bytes that give no result keep flowing.
// rx_stall rises only when both registers are full and the waiting byte
// would give a result.
// reset clears the frame state: the next byte starts a new header, and both
// registers come up empty.
module varint_type_length_deframer #(
	parameter int unsigned MAX_HEADER_BYTES = vtld_pkg::MAX_HEADER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	output logic                         rx_stall,
	input  logic [vtld_pkg::BYTE_W-1:0]  rx_byte,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   kind,
	output logic [vtld_pkg::ACC_W-1:0]   message_type,
	output logic [vtld_pkg::ACC_W-1:0]   message_length,
	output logic [vtld_pkg::BYTE_W-1:0]  payload_byte,
	output logic                         last_of_message
);

	logic                         valid_s1;
	logic [vtld_pkg::BYTE_W-1:0]  byte_s1;
	logic                         res_valid_q;
	vtld_pkg::res_t               res_q;
	vtld_pkg::res_t               core_res;
	logic                         core_has_res;
	logic                         out_free;
	logic                         s1_go;
	logic                         rx_take;

	// stage handshake
	assign out_free = !res_valid_q || !res_stall;
	assign s1_go = valid_s1 && (!core_has_res || out_free);
	assign rx_stall = valid_s1 && !s1_go;
	assign rx_take = rx_valid && !rx_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// header decode and body tagging
	vtld_core #(
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (s1_go),
		.rx_byte (byte_s1),
		.has_res (core_has_res),
		.res     (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && core_has_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && core_has_res) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign kind = res_q.kind;
	assign message_type = res_q.msg_type;
	assign message_length = res_q.msg_len;
	assign payload_byte = res_q.payload;
	assign last_of_message = res_q.last;

endmodule

>>> tb/varint_type_length_deframer_tb.sv
module varint_type_length_deframer_tb;

	localparam int HDR_LIMIT = vtld_pkg::MAX_HEADER_BYTES_DEF;
	localparam int PHASE_BYTES = 450;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [vtld_pkg::BYTE_W-1:0] rx_byte = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] kind;
	logic [vtld_pkg::ACC_W-1:0] message_type;
	logic [vtld_pkg::ACC_W-1:0] message_length;
	logic [vtld_pkg::BYTE_W-1:0] payload_byte;
	logic last_of_message;

	// idling percentages for the link side and the result side
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	int cycles = 0;
	int n_bytes = 0;
	int n_checked = 0;
	int n_payload = 0;
	int n_empty = 0;
	int n_overflow = 0;
	int mismatches = 0;

	// deframer state as predicted from the bytes taken so far
	logic fr_in_body = 1'b0;
	logic fr_type_done = 1'b0;
	int fr_shift = 0;
	logic [4:0] fr_hdr_cnt = '0;
	logic [vtld_pkg::ACC_W-1:0] fr_type = '0;
	logic [vtld_pkg::ACC_W-1:0] fr_len = '0;
	logic [vtld_pkg::ACC_W-1:0] fr_remaining = '0;

	vtld_pkg::res_t pending_results[$];
	logic [7:0] hdr_q[$];

	varint_type_length_deframer #(
		.MAX_HEADER_BYTES(HDR_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.message_type(message_type),
		.message_length(message_length),
		.payload_byte(payload_byte),
		.last_of_message(last_of_message)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("varint_type_length_deframer regression: fail");
			$finish;
		end
	end

	// result side: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// group lands in the accumulator only below bit 32
	function automatic logic [vtld_pkg::ACC_W-1:0] merge_group(
			input logic [vtld_pkg::ACC_W-1:0] acc,
			input logic [6:0] grp, input int sh);
		if (sh < 32)
			return acc | vtld_pkg::ACC_W'(64'(grp) << sh);
		return acc;
	endfunction

	// advance the predicted state by one byte and queue any result it gives
	function automatic void predict_byte(input logic [7:0] b);
		vtld_pkg::res_t want;
		want = '0;
		if (fr_in_body) begin
			want.kind = vtld_pkg::KIND_PAYLOAD;
			want.msg_type = fr_type;
			want.msg_len = fr_len;
			want.payload = b;
			want.last = (fr_remaining <= 1);
			if (want.last) begin
				fr_remaining = '0;
				fr_in_body = 1'b0;
			end else begin
				fr_remaining--;
			end
			pending_results.push_back(want);
			n_payload++;
			return;
		end
		// header byte
		if (fr_hdr_cnt == 0) begin
			fr_type = '0;
			fr_len = '0;
		end
		fr_hdr_cnt++;
		if (!fr_type_done)
			fr_type = merge_group(fr_type, b[6:0], fr_shift);
		else
			fr_len = merge_group(fr_len, b[6:0], fr_shift);
		if (!b[7]) begin
			if (!fr_type_done) begin
				fr_type_done = 1'b1;
				fr_shift = 0;
			end else begin
				fr_type_done = 1'b0;
				fr_shift = 0;
				fr_hdr_cnt = '0;
				if (fr_len == 0) begin
					want.kind = vtld_pkg::KIND_EMPTY;
					want.msg_type = fr_type;
					want.last = 1'b1;
					pending_results.push_back(want);
					n_empty++;
				end else begin
					fr_in_body = 1'b1;
					fr_remaining = fr_len;
				end
				return;
			end
		end else if (fr_shift < 32) begin
			fr_shift += 7;
		end
		// header too long: thrown away
		if (fr_hdr_cnt >= HDR_LIMIT) begin
			fr_type_done = 1'b0;
			fr_shift = 0;
			fr_hdr_cnt = '0;
			want.kind = vtld_pkg::KIND_OVERFLOW;
			pending_results.push_back(want);
			n_overflow++;
		end
	endfunction

	// check each result transfer against the oldest prediction
	always @(posedge clk) begin : check_results
		vtld_pkg::res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing predicted: kind %0d type %0h", kind, message_type);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					mismatches++;
				end
				if (message_type !== want.msg_type) begin
					$error("message_type: expected %0h, actual %0h", want.msg_type,
						message_type);
					mismatches++;
				end
				if (message_length !== want.msg_len) begin
					$error("message_length: expected %0h, actual %0h", want.msg_len,
						message_length);
					mismatches++;
				end
				if (payload_byte !== want.payload) begin
					$error("payload_byte: expected %0h, actual %0h", want.payload,
						payload_byte);
					mismatches++;
				end
				if (last_of_message !== want.last) begin
					$error("last_of_message: expected %0d, actual %0d", want.last,
						last_of_message);
					mismatches++;
				end
			end
		end
	end

	// one link byte transfer, with an optional gap before it
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall !== 1'b0);
		predict_byte(b);
		n_bytes++;
	endtask

	function automatic int varint_bytes(input logic [vtld_pkg::ACC_W-1:0] v);
		int n;
		n = 1;
		while (n < 5 && (v >> (7 * n)) != 0)
			n++;
		return n;
	endfunction

	// encode v in n bytes; bits past bit 31 are filled with junk
	function automatic void push_varint(input logic [vtld_pkg::ACC_W-1:0] v, input int n);
		logic [6:0] grp;
		for (int i = 0; i < n; i++) begin
			if (i < 4)
				grp = 7'(v >> (7 * i));
			else if (i == 4)
				grp = {3'($urandom_range(7)), v[31:28]};
			else
				grp = 7'($urandom_range(127));
			hdr_q.push_back({(i < n - 1) ? 1'b1 : 1'b0, grp});
		end
	endfunction

	function automatic logic [7:0] body_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// header of tn type bytes and ln length bytes, then nbody body bytes
	task automatic send_frame(input logic [vtld_pkg::ACC_W-1:0] t,
			input logic [vtld_pkg::ACC_W-1:0] len,
			input int tn, input int ln, input int nbody);
		hdr_q.delete();
		push_varint(t, tn);
		push_varint(len, ln);
		foreach (hdr_q[i])
			send_byte(hdr_q[i]);
		repeat (nbody)
			send_byte(body_byte());
	endtask

	// a header that never completes; the type ends on byte k (none if k is 0)
	task automatic send_overlong_header(input int k);
		logic [7:0] b;
		for (int i = 0; i < HDR_LIMIT; i++) begin
			b = {1'b1, 7'($urandom_range(127))};
			if (i == k - 1)
				b[7] = 1'b0;
			send_byte(b);
		end
	endtask

	task automatic test_empty_messages();
		send_frame(32'h0, 32'h0, 1, 1, 0);
		send_frame(32'hffff_ffff, 32'h0, 5, 1, 0);
	endtask

	task automatic test_single_byte_body();
		send_frame(32'h1, 32'h1, 1, 1, 1);
	endtask

	// padded varints, the type with junk high groups, completing on the last allowed byte
	task automatic test_header_at_limit();
		send_frame(32'h1234_5678, 32'h0, 6, HDR_LIMIT - 6, 0);
	endtask

	task automatic test_header_overflow();
		send_overlong_header(HDR_LIMIT);
	endtask

	// result side held off while the link keeps offering a long body
	task automatic test_backpressure();
		hold_left = HOLD_CYCLES;
		send_frame(32'h0000_0abc, 32'd48, 2, 1, 48);
	endtask

	// random noise, kept to a one-byte length so any body stays short
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			b = 8'($urandom_range(255));
			if (!fr_in_body && fr_type_done && fr_shift >= 7)
				b[7] = 1'b1;
			send_byte(b);
		end
		// back to the start of a header
		while (fr_in_body || fr_hdr_cnt != 0)
			send_byte(fr_in_body ? body_byte() : 8'h80);
	endtask

	task automatic test_random_traffic();
		logic [vtld_pkg::ACC_W-1:0] t;
		logic [vtld_pkg::ACC_W-1:0] len;
		int tn;
		int ln;
		int start;
		int r;
		start = n_bytes;
		while (n_bytes - start < PHASE_BYTES) begin
			r = $urandom_range(99);
			if (r < 75) begin
				t = vtld_pkg::ACC_W'($urandom) >> $urandom_range(0, 31);
				r = $urandom_range(99);
				if (r < 10)
					len = 0;
				else if (r < 85)
					len = $urandom_range(1, 12);
				else
					len = $urandom_range(13, 64);
				tn = varint_bytes(t);
				ln = varint_bytes(len);
				if ($urandom_range(4) == 0) begin
					tn = $urandom_range(tn, HDR_LIMIT - ln);
					ln = $urandom_range(ln, HDR_LIMIT - tn);
				end
				send_frame(t, len, tn, ln, int'(len));
			end else if (r < 88) begin
				send_overlong_header($urandom_range(0, HDR_LIMIT));
			end else begin
				send_noise();
			end
		end
	endtask

	// largest length: the block stays in the body for the rest of the run
	task automatic test_max_length();
		send_frame(vtld_pkg::ACC_W'($urandom), 32'hffff_ffff, 5, 5, 150);
	endtask

	initial begin : run
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		gap_pct = 16;
		stall_pct = 64;
		test_empty_messages();
		test_single_byte_body();
		test_header_at_limit();
		test_header_overflow();
		test_backpressure();
		test_random_traffic();

		gap_pct = 64;
		stall_pct = 16;
		test_random_traffic();

		gap_pct = 0;
		stall_pct = 0;
		test_random_traffic();
		test_max_length();

		@(negedge clk) rx_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d link bytes in %0d cycles: %0d payload bytes, %0d empty messages,",
			n_bytes, cycles, n_payload, n_empty);
		$display("%0d discarded headers; %0d results checked, %0d mismatches",
			n_overflow, n_checked, mismatches);
		if (mismatches == 0)
			$display("varint_type_length_deframer regression: pass");
		else
			$display("varint_type_length_deframer regression: fail");
		$finish;
	end

endmodule
